// File: hdl/stp_pkg.sv
// ============================================================================
// stp_pkg - shared types and constants of the trapezoidal move profiler
// Codes, register indexes, reset values and the structs passed between the
// top level and the profile core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  // Field widths
  localparam int unsigned RATE_W  = 12;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned CPU_W   = 7;
  localparam int unsigned OVS_W   = 8;
  localparam int unsigned RMS_W   = 20;
  localparam int unsigned SPAN_W  = 21;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Saturation limits
  localparam logic [SPAN_W-1:0] SPAN_MAX = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Register reset values
  localparam logic [RATE_W-1:0]  RST_MIN_RATE   = 12'd321;
  localparam logic [STEP_W-1:0]  RST_RAMP_STEP  = 10'd40;
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 5'd16;
  localparam logic [CPU_W-1:0]   RST_CPU        = 7'd16;
  localparam logic [OVS_W-1:0]   RST_OVERSHOOT  = 8'd3;
  localparam logic [RMS_W-1:0]   RST_RAMP_MIN_SPAN = 20'd700;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPU           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERSHOOT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_MIN_SPAN = 3'd5;

  // Command codes
  localparam logic [1:0] FN_POLL  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_LOAD  = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_STARTED  = 2'd1;
  localparam logic [1:0] EV_REFUSED  = 2'd2;
  localparam logic [1:0] EV_FINISHED = 2'd3;

  // Drive direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  // Move phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_UP     = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DOWN   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [RATE_W-1:0]  min_rate_hz;
    logic [STEP_W-1:0]  ramp_step_hz;
    logic [SCALE_W-1:0] speed_scale;
    logic [CPU_W-1:0]   counts_per_unit;
    logic [OVS_W-1:0]   overshoot_counts;
    logic [RMS_W-1:0]   ramp_min_span;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              func;
    logic                    move_direction;
    logic [7:0]              speed_units;
    logic [15:0]             step_distance;
    logic signed [POS_W-1:0] load_value;
    logic signed [POS_W-1:0] encoder_position;
    logic                    head_limit;
    logic                    tail_limit;
    logic                    ramp_tick;
  } item_t;

  typedef struct packed {
    logic [1:0]        drive_dir;
    logic [RATE_W-1:0] step_rate_hz;
    logic              coil_on;
    logic [1:0]        event_res;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/stp_core.sv
// ============================================================================
// stp_core - move state and single-pass profile update
// Holds the move state and works out, in one pass of logic, the next state
// and the result of one transaction. State advances only when item_en is high.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_en,
  input  wire stp_pkg::item_t  item,
  input  wire stp_pkg::cfg_t   cfg,
  output stp_pkg::result_t     result
);

  // Move state
  stp_pkg::phase_t                   phase, phase_next;
  logic [stp_pkg::POS_W-1:0]         target_position, target_position_next;
  logic [stp_pkg::POS_W-1:0]         goal_count, goal_count_next;
  logic [stp_pkg::SPAN_W-1:0]        span_count, span_count_next;
  logic [stp_pkg::RATE_W-1:0]        current_rate, current_rate_next;
  logic [stp_pkg::RATE_W-1:0]        peak_rate, peak_rate_next;
  logic                              active_direction, active_direction_next;
  logic [1:0]                        event_code;

  // Start arithmetic
  logic [stp_pkg::POS_W-1:0]         start_target;
  logic [38:0]                       goal_prod;
  logic [stp_pkg::POS_W-1:0]         start_goal;
  logic [22:0]                       span_prod;
  logic signed [23:0]                span_raw;
  logic [stp_pkg::SPAN_W-1:0]        start_span;
  logic [12:0]                       peak_prod;
  logic [stp_pkg::RATE_W-1:0]        start_peak;
  logic                              start_limit;

  // Poll arithmetic
  logic                              travel_limit;
  logic signed [32:0]                left;
  logic signed [35:0]                left_ext;
  logic signed [35:0]                left_x3;
  logic                              below_third;
  logic                              reached;
  logic [12:0]                       up_sum;
  logic [stp_pkg::RATE_W-1:0]        up_rate;
  logic [stp_pkg::RATE_W-1:0]        up_after;
  logic [stp_pkg::RATE_W-1:0]        down_rate;
  logic [stp_pkg::RATE_W-1:0]        out_rate;

  // Target, goal, span and peak rate for a new move
  assign start_target = item.move_direction
                      ? target_position - {16'd0, item.step_distance}
                      : target_position + {16'd0, item.step_distance};
  assign goal_prod  = {7'd0, start_target} * {32'd0, cfg.counts_per_unit};
  assign start_goal = item.move_direction
                    ? goal_prod[31:0] + {24'd0, cfg.overshoot_counts}
                    : goal_prod[31:0] - {24'd0, cfg.overshoot_counts};

  assign span_prod = {7'd0, item.step_distance} * {16'd0, cfg.counts_per_unit};
  assign span_raw  = $signed({1'b0, span_prod}) - $signed({16'd0, cfg.overshoot_counts});
  always_comb begin
    if (span_raw[23]) begin
      start_span = '0;
    end else if (span_raw[22:21] != 2'b00) begin
      start_span = stp_pkg::SPAN_MAX;
    end else begin
      start_span = span_raw[20:0];
    end
  end

  assign peak_prod  = {5'd0, item.speed_units} * {8'd0, cfg.speed_scale};
  assign start_peak = peak_prod[12] ? stp_pkg::RATE_MAX : peak_prod[11:0];

  assign start_limit  = item.move_direction ? item.head_limit : item.tail_limit;
  assign travel_limit = active_direction ? item.head_limit : item.tail_limit;

  // Distance left, signed; left < span/3 is the same as 3*left + 3 <= span
  assign left = active_direction
              ? {item.encoder_position[31], item.encoder_position}
                - {goal_count[31], goal_count}
              : {goal_count[31], goal_count}
                - {item.encoder_position[31], item.encoder_position};
  assign left_ext    = {{3{left[32]}}, left};
  assign left_x3     = (left_ext <<< 1) + left_ext + 36'sd3;
  assign below_third = left_x3 <= $signed({15'd0, span_count});

  assign reached = active_direction
                 ? (item.encoder_position <= $signed(goal_count))
                 : (item.encoder_position >= $signed(goal_count));

  // Ramp up and ramp down rates
  assign up_sum   = {1'b0, current_rate} + {3'd0, cfg.ramp_step_hz};
  assign up_rate  = (up_sum > {1'b0, peak_rate}) ? peak_rate : up_sum[11:0];
  assign up_after = item.ramp_tick ? up_rate : current_rate;
  assign down_rate = (current_rate > {2'd0, cfg.ramp_step_hz})
                   ? current_rate - {2'd0, cfg.ramp_step_hz}
                   : '0;

  // Next state
  always_comb begin
    phase_next            = phase;
    target_position_next  = target_position;
    goal_count_next       = goal_count;
    span_count_next       = span_count;
    current_rate_next     = current_rate;
    peak_rate_next        = peak_rate;
    active_direction_next = active_direction;
    event_code            = stp_pkg::EV_NONE;
    unique case (item.func)
      stp_pkg::FN_LOAD: begin
        target_position_next = item.load_value;
      end
      stp_pkg::FN_START: begin
        if (phase == stp_pkg::PH_IDLE) begin
          if (start_limit) begin
            event_code = stp_pkg::EV_REFUSED;
          end else begin
            event_code            = stp_pkg::EV_STARTED;
            active_direction_next = item.move_direction;
            target_position_next  = start_target;
            goal_count_next       = start_goal;
            span_count_next       = start_span;
            peak_rate_next        = start_peak;
            current_rate_next     = cfg.min_rate_hz;
            if (start_span > {1'b0, cfg.ramp_min_span}) begin
              phase_next = (cfg.min_rate_hz < start_peak) ? stp_pkg::PH_UP
                                                          : stp_pkg::PH_CRUISE;
            end else begin
              phase_next = stp_pkg::PH_DOWN;
            end
          end
        end
      end
      stp_pkg::FN_POLL: begin
        if (phase != stp_pkg::PH_IDLE) begin
          if (travel_limit) begin
            phase_next = stp_pkg::PH_IDLE;
            event_code = stp_pkg::EV_FINISHED;
          end else begin
            unique case (phase)
              stp_pkg::PH_UP: begin
                current_rate_next = up_after;
                if (up_after >= peak_rate) begin
                  phase_next = stp_pkg::PH_CRUISE;
                end
              end
              stp_pkg::PH_CRUISE: begin
                if (below_third) begin
                  phase_next = stp_pkg::PH_DOWN;
                end
              end
              stp_pkg::PH_DOWN: begin
                if (reached) begin
                  phase_next = stp_pkg::PH_IDLE;
                  event_code = stp_pkg::EV_FINISHED;
                end else if (item.ramp_tick && (current_rate > cfg.min_rate_hz)) begin
                  current_rate_next = down_rate;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result from the state after the update
  assign out_rate = (current_rate_next < cfg.min_rate_hz) ? cfg.min_rate_hz
                                                          : current_rate_next;
  always_comb begin
    if (phase_next == stp_pkg::PH_IDLE) begin
      result.drive_dir    = stp_pkg::DIR_STOP;
      result.step_rate_hz = '0;
      result.coil_on      = 1'b0;
    end else begin
      result.drive_dir    = active_direction_next ? stp_pkg::DIR_BWD : stp_pkg::DIR_FWD;
      result.step_rate_hz = out_rate;
      result.coil_on      = 1'b1;
    end
    result.event_res = event_code;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= stp_pkg::PH_IDLE;
      target_position  <= '0;
      goal_count       <= '0;
      span_count       <= '0;
      current_rate     <= '0;
      peak_rate        <= '0;
      active_direction <= 1'b0;
    end else if (item_en) begin
      phase            <= phase_next;
      target_position  <= target_position_next;
      goal_count       <= goal_count_next;
      span_count       <= span_count_next;
      current_rate     <= current_rate_next;
      peak_rate        <= peak_rate_next;
      active_direction <= active_direction_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stepper_trapezoid_move_profiler.sv
// ============================================================================
// stepper_trapezoid_move_profiler - trapezoidal step-rate profiler, top level
// Input channel carries move, load and poll commands; each transaction gives
// exactly one result transaction on the output channel.
//
// Usage:
//   - Input channel in_valid/in_ready with the command fields; output channel
//     out_valid/out_ready with drive_dir, step_rate_hz, coil_on, event_res.
//   - Configuration by cfg_we/cfg_index/cfg_data, taken on the clock edge;
//     the user writes only while no transaction is outstanding (unchecked).
//   - Results are registered: result register, or skid register on a stall.
//   - Throughput: one transaction per cycle while in_ready is high, set by the
//     single pass of logic from input to result register (one 32x7 multiply on a start).
//   - A two-entry output buffer (result register plus skid register) keeps
//     in_ready high while one result waits; in_ready drops only when both
//     entries are full, and rises again once the receiver takes a result.
//   - Reset (rst, synchronous) loads the register defaults, parks the move in
//     idle with target, goal, span and rates cleared, and empties the buffer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_move_profiler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        func,
  input  wire logic                              move_direction,
  input  wire logic [7:0]                        speed_units,
  input  wire logic [15:0]                       step_distance,
  input  wire logic signed [stp_pkg::POS_W-1:0]  load_value,
  input  wire logic signed [stp_pkg::POS_W-1:0]  encoder_position,
  input  wire logic                              head_limit,
  input  wire logic                              tail_limit,
  input  wire logic                              ramp_tick,
  // Output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             drive_dir,
  output logic [stp_pkg::RATE_W-1:0]             step_rate_hz,
  output logic                                   coil_on,
  output logic [1:0]                             event_res,
  // Configuration port
  input  wire logic                              cfg_we,
  input  wire logic [stp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [stp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  stp_pkg::cfg_t    cfg;
  stp_pkg::item_t   item;
  stp_pkg::result_t result;
  stp_pkg::result_t out_res;
  stp_pkg::result_t skid_res;
  logic             skid_valid;
  logic             in_fire;
  logic             out_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_rate_hz      <= stp_pkg::RST_MIN_RATE;
      cfg.ramp_step_hz     <= stp_pkg::RST_RAMP_STEP;
      cfg.speed_scale      <= stp_pkg::RST_SPEED_SCALE;
      cfg.counts_per_unit  <= stp_pkg::RST_CPU;
      cfg.overshoot_counts <= stp_pkg::RST_OVERSHOOT;
      cfg.ramp_min_span    <= stp_pkg::RST_RAMP_MIN_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stp_pkg::REG_MIN_RATE:      cfg.min_rate_hz      <= cfg_data[11:0];
        stp_pkg::REG_RAMP_STEP:     cfg.ramp_step_hz     <= cfg_data[9:0];
        stp_pkg::REG_SPEED_SCALE:   cfg.speed_scale      <= cfg_data[4:0];
        stp_pkg::REG_CPU:           cfg.counts_per_unit  <= cfg_data[6:0];
        stp_pkg::REG_OVERSHOOT:     cfg.overshoot_counts <= cfg_data[7:0];
        stp_pkg::REG_RAMP_MIN_SPAN: cfg.ramp_min_span    <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  // Command fields into one bundle
  always_comb begin
    item.func             = func;
    item.move_direction   = move_direction;
    item.speed_units      = speed_units;
    item.step_distance    = step_distance;
    item.load_value       = load_value;
    item.encoder_position = encoder_position;
    item.head_limit       = head_limit;
    item.tail_limit       = tail_limit;
    item.ramp_tick        = ramp_tick;
  end

  stp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item_en (in_fire),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_fire) begin
          skid_valid <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid && !out_ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_res <= result;
      end else begin
        out_res <= result;
      end
    end
  end

  assign drive_dir    = out_res.drive_dir;
  assign step_rate_hz = out_res.step_rate_hz;
  assign coil_on      = out_res.coil_on;
  assign event_res    = out_res.event_res;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");

  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    (in_fire && out_valid && !out_ready) |=> skid_valid)
    else $error("stalled transaction not kept in skid register");

  a_start_moves: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == stp_pkg::EV_STARTED) |-> (coil_on && drive_dir != stp_pkg::DIR_STOP))
    else $error("started move reported without drive");

  a_refuse_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == stp_pkg::EV_REFUSED) |-> (!coil_on && drive_dir == stp_pkg::DIR_STOP))
    else $error("refused move reported as moving");

  a_stop_zero_rate: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !coil_on) |-> (step_rate_hz == '0 && drive_dir == stp_pkg::DIR_STOP))
    else $error("rate or direction set while coil is off");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the trapezoidal stepper move profiler
// Drives move, load and poll commands over the valid/ready input channel and
// checks every result transaction against a cycle-free model of the profile
// (ramp up, cruise, ramp down, limit refusal and abort). Runs a directed
// sequence, then random moves under several register settings and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import stp_pkg::*;

  // spare command code, ignored by the block
  localparam logic [1:0] FN_SPARE = 2'd3;

  // DUT ports
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              func = FN_POLL;
  logic                    move_direction = 1'b0;
  logic [7:0]              speed_units = '0;
  logic [15:0]             step_distance = '0;
  logic signed [POS_W-1:0] load_value = '0;
  logic signed [POS_W-1:0] encoder_position = '0;
  logic                    head_limit = 1'b0;
  logic                    tail_limit = 1'b0;
  logic                    ramp_tick = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              drive_dir;
  logic [RATE_W-1:0]       step_rate_hz;
  logic                    coil_on;
  logic [1:0]              event_res;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Run control
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_items = 0;
  int unsigned fail_count = 0;

  // Profile model state and register copy
  cfg_t              cfg_q;
  phase_t            mv_phase;
  logic [POS_W-1:0]  tgt_pos;
  logic [POS_W-1:0]  goal_cnt;
  logic [SPAN_W-1:0] span_cnt;
  logic [RATE_W-1:0] cur_rate;
  logic [RATE_W-1:0] pk_rate;
  logic              mv_dir;

  // Expected drive outputs, oldest first
  result_t drive_queue[$];
  result_t want_res;

  stepper_trapezoid_move_profiler dut (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Profile model
  // ---------------------------------------------------------------------------

  // Outputs as seen in the current phase
  function automatic result_t drive_outputs(logic [1:0] ev);
    result_t r;
    if (mv_phase == PH_IDLE) begin
      r.drive_dir    = DIR_STOP;
      r.step_rate_hz = '0;
      r.coil_on      = 1'b0;
    end else begin
      r.drive_dir    = mv_dir ? DIR_BWD : DIR_FWD;
      r.step_rate_hz = (cur_rate < cfg_q.min_rate_hz) ? cfg_q.min_rate_hz : cur_rate;
      r.coil_on      = 1'b1;
    end
    r.event_res = ev;
    return r;
  endfunction

  // Advance the profile by one command, return the expected result
  function automatic result_t advance_profile(item_t c);
    longint      sp;
    longint      goal_s;
    longint      enc_s;
    longint      left;
    int unsigned pk;
    int unsigned r;
    goal_s = $signed(goal_cnt);
    enc_s  = $signed(c.encoder_position);
    case (c.func)
      FN_LOAD: begin
        tgt_pos = c.load_value;
        return drive_outputs(EV_NONE);
      end
      FN_START: begin
        if (mv_phase != PH_IDLE) return drive_outputs(EV_NONE);
        if (c.move_direction ? c.head_limit : c.tail_limit) return drive_outputs(EV_REFUSED);
        mv_dir = c.move_direction;
        if (!mv_dir) begin
          tgt_pos  = tgt_pos + {16'b0, c.step_distance};
          goal_cnt = tgt_pos * {25'b0, cfg_q.counts_per_unit} - {24'b0, cfg_q.overshoot_counts};
        end else begin
          tgt_pos  = tgt_pos - {16'b0, c.step_distance};
          goal_cnt = tgt_pos * {25'b0, cfg_q.counts_per_unit} + {24'b0, cfg_q.overshoot_counts};
        end
        sp = longint'(c.step_distance) * longint'(cfg_q.counts_per_unit)
             - longint'(cfg_q.overshoot_counts);
        if (sp < 0) sp = 0;
        if (sp > longint'(SPAN_MAX)) sp = longint'(SPAN_MAX);
        span_cnt = sp[SPAN_W-1:0];
        pk       = c.speed_units * cfg_q.speed_scale;
        pk_rate  = (pk > int'(RATE_MAX)) ? RATE_MAX : pk[RATE_W-1:0];
        cur_rate = cfg_q.min_rate_hz;
        if (span_cnt > {1'b0, cfg_q.ramp_min_span})
          mv_phase = (cur_rate < pk_rate) ? PH_UP : PH_CRUISE;
        else
          mv_phase = PH_DOWN;
        return drive_outputs(EV_STARTED);
      end
      FN_POLL: begin
        if (mv_phase == PH_IDLE) return drive_outputs(EV_NONE);
        // limit in the direction of travel aborts the move
        if (mv_dir ? c.head_limit : c.tail_limit) begin
          mv_phase = PH_IDLE;
          return drive_outputs(EV_FINISHED);
        end
        case (mv_phase)
          PH_UP: begin
            if (c.ramp_tick) begin
              r = cur_rate + cfg_q.ramp_step_hz;
              cur_rate = (r > pk_rate) ? pk_rate : r[RATE_W-1:0];
            end
            if (cur_rate >= pk_rate) mv_phase = PH_CRUISE;
          end
          PH_CRUISE: begin
            left = mv_dir ? enc_s - goal_s : goal_s - enc_s;
            if (left < longint'(span_cnt / 3)) mv_phase = PH_DOWN;
          end
          default: begin
            if (mv_dir ? (enc_s <= goal_s) : (enc_s >= goal_s)) begin
              mv_phase = PH_IDLE;
              return drive_outputs(EV_FINISHED);
            end
            if (c.ramp_tick && cur_rate > cfg_q.min_rate_hz)
              cur_rate = (cur_rate > cfg_q.ramp_step_hz) ? cur_rate - cfg_q.ramp_step_hz : '0;
          end
        endcase
        return drive_outputs(EV_NONE);
      end
      default: return drive_outputs(EV_NONE);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command builders; unused fields carry random noise
  // ---------------------------------------------------------------------------

  function automatic item_t noise_item();
    logic [95:0] raw;
    item_t       c;
    raw = {$urandom, $urandom, $urandom};
    c   = raw[$bits(item_t)-1:0];
    return c;
  endfunction

  function automatic item_t poll_item(logic signed [POS_W-1:0] enc, logic head, logic tail,
                                      logic tick);
    item_t c;
    c = noise_item();
    c.func             = FN_POLL;
    c.encoder_position = enc;
    c.head_limit       = head;
    c.tail_limit       = tail;
    c.ramp_tick        = tick;
    return c;
  endfunction

  function automatic item_t start_item(logic dir, logic [7:0] speed, logic [15:0] move_len,
                                       logic head, logic tail);
    item_t c;
    c = noise_item();
    c.func           = FN_START;
    c.move_direction = dir;
    c.speed_units    = speed;
    c.step_distance  = move_len;
    c.head_limit     = head;
    c.tail_limit     = tail;
    return c;
  endfunction

  function automatic item_t other_item(logic [1:0] fn, logic signed [POS_W-1:0] val);
    item_t c;
    c = noise_item();
    c.func       = fn;
    c.load_value = val;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel handling
  // ---------------------------------------------------------------------------

  // Send one command transaction, then record its expected result
  task automatic send_cmd(input item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    func             <= c.func;
    move_direction   <= c.move_direction;
    speed_units      <= c.speed_units;
    step_distance    <= c.step_distance;
    load_value       <= c.load_value;
    encoder_position <= c.encoder_position;
    head_limit       <= c.head_limit;
    tail_limit       <= c.tail_limit;
    ramp_tick        <= c.ramp_tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_queue.push_back(advance_profile(c));
    sent_items++;
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write all six registers back to back; block must be idle
  task automatic load_settings(input cfg_t s);
    write_reg(REG_MIN_RATE,      CFG_DATA_W'(s.min_rate_hz));
    write_reg(REG_RAMP_STEP,     CFG_DATA_W'(s.ramp_step_hz));
    write_reg(REG_SPEED_SCALE,   CFG_DATA_W'(s.speed_scale));
    write_reg(REG_CPU,           CFG_DATA_W'(s.counts_per_unit));
    write_reg(REG_OVERSHOOT,     CFG_DATA_W'(s.overshoot_counts));
    write_reg(REG_RAMP_MIN_SPAN, CFG_DATA_W'(s.ramp_min_span));
    cfg_we <= 1'b0;
    cfg_q = s;
    @(posedge clk);
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.min_rate_hz      = RATE_W'($urandom_range(1, 600));
    s.ramp_step_hz     = STEP_W'($urandom_range(1, 1023));
    s.speed_scale      = SCALE_W'($urandom_range(1, 16));
    s.counts_per_unit  = CPU_W'($urandom_range(1, 64));
    s.overshoot_counts = OVS_W'($urandom_range(0, 255));
    s.ramp_min_span    = RMS_W'($urandom_range(0, 3000));
    return s;
  endfunction

  // Receiver: random back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Result checker: each accepted transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (drive_queue.size() == 0) begin
        report_mismatch("result with none pending", event_res, 0);
      end else begin
        want_res = drive_queue.pop_front();
        if (drive_dir !== want_res.drive_dir)
          report_mismatch("drive_dir", drive_dir, want_res.drive_dir);
        if (step_rate_hz !== want_res.step_rate_hz)
          report_mismatch("step_rate_hz", step_rate_hz, want_res.step_rate_hz);
        if (coil_on !== want_res.coil_on)
          report_mismatch("coil_on", coil_on, want_res.coil_on);
        if (event_res !== want_res.event_res)
          report_mismatch("event_res", event_res, want_res.event_res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, every command and the named corner cases, reset settings
  task automatic test_directed();
    send_cmd(poll_item($urandom, 1'b1, 1'b1, 1'b1));           // poll while idle
    send_cmd(other_item(FN_SPARE, $urandom));                 // unused code
    send_cmd(other_item(FN_LOAD, 32'sh7FFFFFFF));
    send_cmd(other_item(FN_LOAD, 32'sh80000000));
    send_cmd(other_item(FN_LOAD, 32'sh00000000));
    send_cmd(start_item(1'b0, 8'd50, 16'd10, 1'b0, 1'b1));    // refused at tail
    send_cmd(start_item(1'b1, 8'd50, 16'd10, 1'b1, 1'b0));    // refused at head
    // short move: no ramp up
    send_cmd(start_item(1'b0, 8'd10, 16'd1, 1'b1, 1'b0));
    send_cmd(start_item(1'b1, 8'd99, 16'd5, 1'b0, 1'b0));     // ignored while moving
    send_cmd(poll_item(32'sd0, 1'b0, 1'b0, 1'b1));
    send_cmd(poll_item(32'sd13, 1'b0, 1'b0, 1'b0));
    // longest, fastest move, aborted at the tail
    send_cmd(start_item(1'b0, 8'hFF, 16'hFFFF, 1'b0, 1'b0));
    send_cmd(poll_item($urandom, 1'b1, 1'b0, 1'b1));
    send_cmd(poll_item($urandom, 1'b0, 1'b0, 1'b1));
    send_cmd(poll_item($urandom, 1'b0, 1'b1, 1'b0));
    // zero distance backward, goal met at once
    send_cmd(start_item(1'b1, 8'hFF, 16'd0, 1'b0, 1'b0));
    send_cmd(poll_item(32'sh80000000, 1'b0, 1'b0, 1'b1));
    // zero speed: straight to cruise, then encoder extremes
    send_cmd(start_item(1'b0, 8'd0, 16'd100, 1'b0, 1'b0));
    send_cmd(poll_item(32'sh80000000, 1'b0, 1'b0, 1'b1));
    send_cmd(poll_item(32'sh7FFFFFFF, 1'b0, 1'b0, 1'b0));
    send_cmd(poll_item(32'sh7FFFFFFF, 1'b0, 1'b0, 1'b0));
    // peak just above the floor: one tick reaches cruise
    send_cmd(start_item(1'b0, 8'd21, 16'd100, 1'b0, 1'b0));
    send_cmd(poll_item($urandom, 1'b0, 1'b0, 1'b1));
    send_cmd(poll_item($urandom, 1'b0, 1'b1, 1'b1));
  endtask

  // One random move: start, then polls with the encoder closing on the goal
  task automatic run_move();
    item_t       c;
    longint      rem;
    int unsigned polls;
    int unsigned roll;
    logic        travel_limit;
    // occasional traffic while stopped
    if ($urandom_range(99) < 15) begin
      c = noise_item();
      c.func = ($urandom_range(1) == 1) ? FN_LOAD : FN_POLL;
      send_cmd(c);
    end
    c = noise_item();
    c.func = FN_START;
    if ($urandom_range(99) < 70) c.speed_units[7:6] = '0;
    roll = $urandom_range(99);
    if (roll < 60) c.step_distance[15:7] = '0;
    else if (roll < 85) c.step_distance[15:11] = '0;
    if ($urandom_range(99) >= 8) begin
      if (c.move_direction) c.head_limit = 1'b0;
      else c.tail_limit = 1'b0;
    end
    send_cmd(c);
    if (mv_phase == PH_IDLE) return;
    rem   = longint'(span_cnt) + longint'($urandom_range(span_cnt / 4 + 2));
    polls = 0;
    while (mv_phase != PH_IDLE && polls < 60) begin
      roll = $urandom_range(99);
      c = noise_item();
      if (roll < 4) c.func = FN_LOAD;
      else if (roll < 7) c.func = FN_START;
      else if (roll < 8) c.func = FN_SPARE;
      else begin
        c.func = FN_POLL;
        c.ramp_tick = ($urandom_range(99) < 75);
        travel_limit = ($urandom_range(99) < 2);
        if (mv_dir) c.head_limit = travel_limit;
        else c.tail_limit = travel_limit;
        // axis only advances once past the ramp up
        if (mv_phase != PH_UP) rem = rem - longint'($urandom_range(span_cnt / 4 + 1));
        if ($urandom_range(99) >= 3)
          c.encoder_position = mv_dir ? goal_cnt + rem[31:0] : goal_cnt - rem[31:0];
      end
      send_cmd(c);
      polls++;
    end
    // still moving: hit the end switch
    if (mv_phase != PH_IDLE)
      send_cmd(poll_item($urandom, mv_dir, !mv_dir, ($urandom_range(1) == 1)));
  endtask

  task automatic run_moves(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent_items + count;
    while (sent_items < stop_at) run_move();
  endtask

  // Reset settings written back, full rate both sides
  task automatic test_steady_stream();
    cfg_t s;
    s.min_rate_hz      = RST_MIN_RATE;
    s.ramp_step_hz     = RST_RAMP_STEP;
    s.speed_scale      = RST_SPEED_SCALE;
    s.counts_per_unit  = RST_CPU;
    s.overshoot_counts = RST_OVERSHOOT;
    s.ramp_min_span    = RST_RAMP_MIN_SPAN;
    wait_drained();
    load_settings(s);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_moves(290);
  endtask

  // Lowest nonzero rate, step, scale and counts, zero overshoot and span, sparse sender
  task automatic test_sparse_sender();
    cfg_t s;
    s.min_rate_hz      = RATE_W'(1);
    s.ramp_step_hz     = STEP_W'(1);
    s.speed_scale      = SCALE_W'(1);
    s.counts_per_unit  = CPU_W'(1);
    s.overshoot_counts = OVS_W'(0);
    s.ramp_min_span    = RMS_W'(0);
    wait_drained();
    load_settings(s);
    send_idle_pct = 82;
    stall_pct     = 0;
    run_moves(290);
  endtask

  // Highest rate, ramp step, overshoot and span settings, slow receiver
  task automatic test_slow_receiver();
    cfg_t s;
    s.min_rate_hz      = RATE_W'(4095);
    s.ramp_step_hz     = STEP_W'(1023);
    s.speed_scale      = SCALE_W'(16);
    s.counts_per_unit  = CPU_W'(64);
    s.overshoot_counts = OVS_W'(255);
    s.ramp_min_span    = RMS_W'(1048575);
    wait_drained();
    load_settings(s);
    send_idle_pct = 0;
    stall_pct     = 82;
    run_moves(290);
  endtask

  // Random settings, idling on both sides, sender pauses for a full drain
  task automatic test_mixed_idling();
    wait_drained();
    load_settings(random_settings());
    send_idle_pct = 25;
    stall_pct     = 25;
    run_moves(145);
    wait_drained();
    load_settings(random_settings());
    run_moves(145);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_q.min_rate_hz      = RST_MIN_RATE;
    cfg_q.ramp_step_hz     = RST_RAMP_STEP;
    cfg_q.speed_scale      = RST_SPEED_SCALE;
    cfg_q.counts_per_unit  = RST_CPU;
    cfg_q.overshoot_counts = RST_OVERSHOOT;
    cfg_q.ramp_min_span    = RST_RAMP_MIN_SPAN;
    mv_phase = PH_IDLE;
    tgt_pos  = '0;
    goal_cnt = '0;
    span_cnt = '0;
    cur_rate = '0;
    pk_rate  = '0;
    mv_dir   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_steady_stream();
    test_sparse_sender();
    test_slow_receiver();
    test_mixed_idling();
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
